### hw/rtl/drik_pkg.sv
// Shared types, constants and fixed-point helpers for the delta robot
// inverse kinematics core. No dependencies.
`timescale 1ns / 1ps
package drik_pkg;

  // Working format: Q16, carried in 24-bit signed words
  localparam int FRAC_BITS  = 16;
  localparam int WORK_W     = 24;
  localparam int ANGLE_ITER = 20;
  localparam int ANG_W      = 32;
  localparam int CORD_W     = 45;
  localparam int SQ_BITS    = 20;
  localparam int V_W        = 2 * SQ_BITS;
  localparam int REM_W      = SQ_BITS + 4;
  localparam int STEP_W     = 20;
  localparam int SPR_W      = 20;
  localparam int LEN_W      = 16;
  localparam int CFG_W      = 20;
  localparam int IDX_W      = 3;
  // Register stages ahead of the arm solvers, and fixed arm stages
  // (squares, discriminant, root digits, numerator, three norm, two scale)
  localparam int FRONT_DEPTH = 6;
  localparam int ARM_FIXED   = SQ_BITS + 8;

  localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;
  localparam logic [19:0] RECIP3    = 20'd349526;
  localparam logic signed [63:0] NORM_LIM = 64'sh0000_0100_0000_0000;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_BASE_SIDE     = 3'd0;
  localparam logic [IDX_W-1:0] REG_PLATFORM_SIDE = 3'd1;
  localparam logic [IDX_W-1:0] REG_UPPER_LINK    = 3'd2;
  localparam logic [IDX_W-1:0] REG_LOWER_LINK    = 3'd3;
  localparam logic [IDX_W-1:0] REG_STEPS_PER_REV = 3'd4;

  typedef struct packed {
    logic zero;   // denominator is zero
    logic nn;     // numerator is zero or positive
    logic fault;  // reach fault for this arm
  } arm_flag_t;

  // Q16 product, floored
  function automatic logic signed [WORK_W-1:0] fmul(input logic signed [WORK_W-1:0] a,
                                                   input logic signed [WORK_W-1:0] b);
    logic signed [2*WORK_W-1:0] p;
    p = a * b;
    return p[FRAC_BITS+WORK_W-1:FRAC_BITS];
  endfunction

  // Product with sqrt(3), floored
  function automatic logic signed [WORK_W-1:0] ms3(input logic signed [WORK_W-1:0] a);
    logic signed [WORK_W+31:0] p;
    logic signed [31:0] k;
    k = $signed({1'b0, SQRT3_Q30});
    p = a * k;
    return p[WORK_W+29:30];
  endfunction

  // Divide a non-negative value below 2^19 by three
  function automatic logic signed [WORK_W-1:0] div3(input logic signed [WORK_W-1:0] v);
    logic [WORK_W+19:0] p;
    p = $unsigned(v) * RECIP3;
    return $signed(p[WORK_W+19:20]);
  endfunction

  // Both operands still inside the normalization window
  function automatic logic in_rng(input logic signed [63:0] x, input logic signed [63:0] y);
    return (x < NORM_LIM) && (y < NORM_LIM) && (y > -NORM_LIM);
  endfunction

  // atan(2^-i)/pi in Q30 half turns
  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
    logic signed [ANG_W-1:0] r;
    unique case (i)
      5'd0:  r = 32'sd268435456;
      5'd1:  r = 32'sd158466703;
      5'd2:  r = 32'sd83729454;
      5'd3:  r = 32'sd42502378;
      5'd4:  r = 32'sd21333666;
      5'd5:  r = 32'sd10677233;
      5'd6:  r = 32'sd5339919;
      5'd7:  r = 32'sd2670123;
      5'd8:  r = 32'sd1335082;
      5'd9:  r = 32'sd667543;
      5'd10: r = 32'sd333772;
      5'd11: r = 32'sd166886;
      5'd12: r = 32'sd83443;
      5'd13: r = 32'sd41722;
      5'd14: r = 32'sd20861;
      5'd15: r = 32'sd10430;
      5'd16: r = 32'sd5215;
      5'd17: r = 32'sd2608;
      5'd18: r = 32'sd1304;
      5'd19: r = 32'sd652;
      5'd20: r = 32'sd326;
      5'd21: r = 32'sd163;
      5'd22: r = 32'sd81;
      5'd23: r = 32'sd41;
      5'd24: r = 32'sd20;
      5'd25: r = 32'sd10;
      5'd26: r = 32'sd5;
      5'd27: r = 32'sd3;
      5'd28: r = 32'sd1;
      5'd29: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/drik_arm.sv
// Pipelined solver for one arm: discriminant, digit-serial root, CORDIC
// angle and step scaling. Depends on drik_pkg.
`timescale 1ns / 1ps
module drik_arm import drik_pkg::*; #(
  parameter int ITER = ANGLE_ITER
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [WORK_W-1:0] e,
  input  logic signed [WORK_W-1:0] f,
  input  logic signed [WORK_W-1:0] g,
  input  logic [SPR_W-1:0]         spr,
  output logic [STEP_W-1:0]        steps,
  output logic                     fault
);

  // Squares and denominator
  logic signed [WORK_W-1:0] ee_q, ff_q, gg_q, nf1_q, den1_q;
  always_ff @(posedge clk) begin
    if (en) begin
      ee_q   <= fmul(e, e);
      ff_q   <= fmul(f, f);
      gg_q   <= fmul(g, g);
      nf1_q  <= -f;
      den1_q <= g - e;
    end
  end

  // Discriminant magnitude, widened for the root
  logic signed [WORK_W-1:0] disc;
  logic [WORK_W-1:0]        mag;
  assign disc = ee_q + ff_q - gg_q;
  assign mag  = disc[WORK_W-1] ? $unsigned(-disc) : $unsigned(disc);

  logic [REM_W-1:0]         sq_rem  [SQ_BITS+1];
  logic [SQ_BITS-1:0]       sq_root [SQ_BITS+1];
  logic [V_W-1:0]           sq_v    [SQ_BITS+1];
  logic                     sq_neg  [SQ_BITS+1];
  logic signed [WORK_W-1:0] sq_nf   [SQ_BITS+1];
  logic signed [WORK_W-1:0] sq_den  [SQ_BITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_v[0]    <= {mag[V_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      sq_neg[0]  <= disc[WORK_W-1];
      sq_nf[0]   <= nf1_q;
      sq_den[0]  <= den1_q;
    end
  end

  // Square root, one result bit per stage
  for (genvar k = 0; k < SQ_BITS; k++) begin : g_sqrt
    logic [REM_W-1:0] rn, tr;
    assign rn = {sq_rem[k][REM_W-3:0], sq_v[k][V_W-1-2*k -: 2]};
    assign tr = {{(REM_W-SQ_BITS-2){1'b0}}, sq_root[k], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        if (rn >= tr) begin
          sq_rem[k+1]  <= rn - tr;
          sq_root[k+1] <= {sq_root[k][SQ_BITS-2:0], 1'b1};
        end else begin
          sq_rem[k+1]  <= rn;
          sq_root[k+1] <= {sq_root[k][SQ_BITS-2:0], 1'b0};
        end
        sq_v[k+1]   <= sq_v[k];
        sq_neg[k+1] <= sq_neg[k];
        sq_nf[k+1]  <= sq_nf[k];
        sq_den[k+1] <= sq_den[k];
      end
    end
  end

  // Numerator, vectoring operands and fault flags
  logic signed [WORK_W-1:0] sroot, num, den;
  logic                     dzero, dpos;
  assign den   = sq_den[SQ_BITS];
  assign sroot = sq_neg[SQ_BITS] ? -$signed({{(WORK_W-SQ_BITS){1'b0}}, sq_root[SQ_BITS]})
                                 :  $signed({{(WORK_W-SQ_BITS){1'b0}}, sq_root[SQ_BITS]});
  assign num   = sq_nf[SQ_BITS] - sroot;
  assign dzero = (den == '0);
  assign dpos  = !den[WORK_W-1] && !dzero;

  logic signed [63:0] nx_q, ny_q;
  arm_flag_t          fl_n_q;
  always_ff @(posedge clk) begin
    if (en) begin
      nx_q         <= 64'(dpos ? den : -den);
      ny_q         <= 64'(dpos ? num : -num);
      fl_n_q.zero  <= dzero;
      fl_n_q.nn    <= !num[WORK_W-1];
      fl_n_q.fault <= dzero || sq_neg[SQ_BITS];
    end
  end

  // Normalize: coarse shifts, then fine shifts, then the last doubling
  logic signed [63:0] a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
  logic signed [63:0] mx_q, my_q, px_q, py_q;
  arm_flag_t          fl_m_q, fl_p_q;

  always_comb begin
    a1x = in_rng(nx_q <<< 32, ny_q <<< 32) ? nx_q <<< 32 : nx_q;
    a1y = in_rng(nx_q <<< 32, ny_q <<< 32) ? ny_q <<< 32 : ny_q;
    a2x = in_rng(a1x <<< 16, a1y <<< 16) ? a1x <<< 16 : a1x;
    a2y = in_rng(a1x <<< 16, a1y <<< 16) ? a1y <<< 16 : a1y;
    b1x = in_rng(a2x <<< 8, a2y <<< 8) ? a2x <<< 8 : a2x;
    b1y = in_rng(a2x <<< 8, a2y <<< 8) ? a2y <<< 8 : a2y;
  end

  always_comb begin
    b2x = in_rng(mx_q <<< 4, my_q <<< 4) ? mx_q <<< 4 : mx_q;
    b2y = in_rng(mx_q <<< 4, my_q <<< 4) ? my_q <<< 4 : my_q;
    if (in_rng(b2x <<< 2, b2y <<< 2)) begin
      b2x = b2x <<< 2;
      b2y = b2y <<< 2;
    end
    if (in_rng(b2x <<< 1, b2y <<< 1)) begin
      b2x = b2x <<< 1;
      b2y = b2y <<< 1;
    end
  end

  logic signed [CORD_W-1:0] cx [ITER+1];
  logic signed [CORD_W-1:0] cy [ITER+1];
  logic signed [ANG_W-1:0]  ca [ITER+1];
  arm_flag_t                cf [ITER+1];

  always_ff @(posedge clk) begin
    if (en) begin
      mx_q   <= b1x;
      my_q   <= b1y;
      fl_m_q <= fl_n_q;
      px_q   <= b2x;
      py_q   <= b2y;
      fl_p_q <= fl_m_q;
      cx[0]  <= CORD_W'(px_q <<< 1);
      cy[0]  <= CORD_W'(py_q <<< 1);
      ca[0]  <= '0;
      cf[0]  <= fl_p_q;
    end
  end

  // CORDIC vectoring, one rotation per stage
  for (genvar i = 0; i < ITER; i++) begin : g_cordic
    logic signed [CORD_W-1:0] dx, dy;
    logic signed [ANG_W-1:0]  at;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;
    assign at = atan_q30(5'(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy[i][CORD_W-1]) begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          ca[i+1] <= ca[i] + at;
        end else begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          ca[i+1] <= ca[i] - at;
        end
        cf[i+1] <= cf[i];
      end
    end
  end

  // Scale the angle to steps
  logic signed [52:0] nang_w, spr_w, prod_q, rnd;
  arm_flag_t          fl_s_q;
  assign nang_w = 53'(-ca[ITER]);
  assign spr_w  = $signed({33'd0, spr});

  always_ff @(posedge clk) begin
    if (en) begin
      prod_q <= nang_w * spr_w;
      fl_s_q <= cf[ITER];
    end
  end

  // Truncate toward zero; saturate on a zero denominator
  logic signed [52:0]     quo;
  logic [STEP_W-1:0]      half;
  assign rnd  = prod_q[52] ? prod_q + 53'sd1073741823 : prod_q;
  assign quo  = rnd >>> 30;
  assign half = {1'b0, spr[SPR_W-1:1]};

  always_ff @(posedge clk) begin
    if (en) begin
      if (fl_s_q.zero) begin
        steps <= fl_s_q.nn ? -half : half;
      end else begin
        steps <= quo[STEP_W-1:0];
      end
      fault <= fl_s_q.fault;
    end
  end

endmodule

### hw/rtl/delta_robot_inverse_kinematics_core.sv
// Delta robot inverse kinematics core: geometry front end and three arm
// solvers. Depends on drik_pkg and drik_arm.
//
// Usage: a target point (target_x, target_y, target_z, signed Q16 m) is
// taken on the input request channel when in_valid is high and in_stall is
// low. The result request (arm1..3_steps, reach_fault) is offered on
// out_valid and taken when out_stall is low.
// The pipe depth comes mainly from the 20-stage root digit pipeline and the
// CORDIC rotation stages. Throughput is one point per cycle while no valid
// result is stalled; every stage is a register and the whole pipe advances
// together. When the receiver stalls a valid result, the pipe holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Geometry registers are written through cfg_we/cfg_index/cfg_data; the
// user must do so only while no point is in flight, which the block does
// not enforce. Unknown indexes are dropped. Reset (rst, synchronous)
// clears all valid bits and loads the default geometry and 180000 steps
// per revolution.
`timescale 1ns / 1ps
module delta_robot_inverse_kinematics_core import drik_pkg::*; #(
  parameter int ITER = ANGLE_ITER
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [15:0]       target_x,
  input  logic signed [15:0]       target_y,
  input  logic signed [16:0]       target_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [STEP_W-1:0] arm1_steps,
  output logic signed [STEP_W-1:0] arm2_steps,
  output logic signed [STEP_W-1:0] arm3_steps,
  output logic [2:0]               reach_fault,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  localparam int DEPTH = FRONT_DEPTH + ARM_FIXED + ITER;

  // Configuration registers
  logic [LEN_W-1:0] base_side, platform_side, upper_link, lower_link;
  logic [SPR_W-1:0] steps_per_rev;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_side     <= 16'd34053;
      platform_side <= 16'd5675;
      upper_link    <= 16'd11469;
      lower_link    <= 16'd22938;
      steps_per_rev <= 20'd180000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_SIDE:     base_side     <= cfg_data[LEN_W-1:0];
        REG_PLATFORM_SIDE: platform_side <= cfg_data[LEN_W-1:0];
        REG_UPPER_LINK:    upper_link    <= cfg_data[LEN_W-1:0];
        REG_LOWER_LINK:    lower_link    <= cfg_data[LEN_W-1:0];
        REG_STEPS_PER_REV: steps_per_rev <= cfg_data[SPR_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: hold everything while a result waits
  logic             adv;
  logic [DEPTH-1:0] vld;
  assign adv       = !(vld[DEPTH-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // Working-format views of the ports and registers
  logic signed [WORK_W-1:0] xi, yi, zi, sbi, spi, ul, ll;
  assign xi  = WORK_W'(target_x);
  assign yi  = WORK_W'(target_y);
  assign zi  = WORK_W'(target_z);
  assign sbi = $signed({{(WORK_W-LEN_W){1'b0}}, base_side});
  assign spi = $signed({{(WORK_W-LEN_W){1'b0}}, platform_side});
  assign ul  = $signed({{(WORK_W-LEN_W){1'b0}}, upper_link});
  assign ll  = $signed({{(WORK_W-LEN_W){1'b0}}, lower_link});

  // Stage 1: squares and sqrt(3) products
  logic signed [WORK_W-1:0] t1_x, t1_y, t1_msb, t1_msp, t1_sph, t1_r2, t1_lk, t1_fz;
  always_ff @(posedge clk) begin
    if (adv) begin
      t1_x   <= xi;
      t1_y   <= yi;
      t1_msb <= ms3(sbi);
      t1_msp <= ms3(spi);
      t1_sph <= spi >>> 1;
      t1_r2  <= fmul(xi, xi) + fmul(yi, yi) + fmul(zi, zi);
      t1_lk  <= fmul(ul, ul) - fmul(ll, ll);
      t1_fz  <= fmul(zi, ul) <<< 1;
    end
  end

  // Stage 2: triangle offsets
  logic signed [WORK_W-1:0] t2_x, t2_y, t2_wb, t2_wp, t2_up, t2_sph, t2_cm, t2_fz;
  always_ff @(posedge clk) begin
    if (adv) begin
      t2_x   <= t1_x;
      t2_y   <= t1_y;
      t2_wb  <= div3(t1_msb >>> 1);
      t2_wp  <= div3(t1_msp >>> 1);
      t2_up  <= div3(t1_msp);
      t2_sph <= t1_sph;
      t2_cm  <= t1_r2 + t1_lk;
      t2_fz  <= t1_fz;
    end
  end

  // Stage 3: a, c and sqrt(3)*wb
  logic signed [WORK_W-1:0] t3_x, t3_y, t3_a, t3_c, t3_mw, t3_sph, t3_cm, t3_fz;
  always_ff @(posedge clk) begin
    if (adv) begin
      t3_x   <= t2_x;
      t3_y   <= t2_y;
      t3_a   <= t2_wb - t2_up;
      t3_c   <= t2_wp - (t2_wb >>> 1);
      t3_mw  <= ms3(t2_wb);
      t3_sph <= t2_sph;
      t3_cm  <= t2_cm;
      t3_fz  <= t2_fz;
    end
  end

  // Stage 4: b and arm one terms
  logic signed [WORK_W-1:0] t4_x, t4_y, t4_b, t4_c, t4_e1, t4_aa, t4_ya, t4_cm, t4_fz;
  always_ff @(posedge clk) begin
    if (adv) begin
      t4_x  <= t3_x;
      t4_y  <= t3_y;
      t4_b  <= t3_sph - (t3_mw >>> 1);
      t4_c  <= t3_c;
      t4_e1 <= fmul(ul, t3_y + t3_a) <<< 1;
      t4_aa <= fmul(t3_a, t3_a);
      t4_ya <= fmul(t3_y, t3_a);
      t4_cm <= t3_cm;
      t4_fz <= t3_fz;
    end
  end

  // Stage 5: g1 and arm two/three products
  logic signed [WORK_W-1:0] t5_y, t5_c, t5_e1, t5_g1, t5_sx, t5_sxm, t5_bc2;
  logic signed [WORK_W-1:0] t5_xb, t5_yc, t5_cm, t5_fz;
  always_ff @(posedge clk) begin
    if (adv) begin
      t5_y   <= t4_y;
      t5_c   <= t4_c;
      t5_e1  <= t4_e1;
      t5_g1  <= t4_cm + t4_aa + (t4_ya <<< 1);
      t5_sx  <= ms3(t4_x + t4_b);
      t5_sxm <= ms3(t4_x - t4_b);
      t5_bc2 <= fmul(t4_b, t4_b) + fmul(t4_c, t4_c);
      t5_xb  <= fmul(t4_x, t4_b);
      t5_yc  <= fmul(t4_y, t4_c);
      t5_cm  <= t4_cm;
      t5_fz  <= t4_fz;
    end
  end

  // Stage 6: E and G of arms two and three
  logic signed [WORK_W-1:0] t6_e1, t6_g1, t6_e2, t6_g2, t6_e3, t6_g3, t6_fz;
  always_ff @(posedge clk) begin
    if (adv) begin
      t6_e1 <= t5_e1;
      t6_g1 <= t5_g1;
      t6_e2 <= -fmul(ul, t5_sx + t5_y + t5_c);
      t6_e3 <= fmul(ul, t5_sxm - t5_y - t5_c);
      t6_g2 <= t5_cm + t5_bc2 + ((t5_xb + t5_yc) <<< 1);
      t6_g3 <= t5_cm + t5_bc2 + ((t5_yc - t5_xb) <<< 1);
      t6_fz <= t5_fz;
    end
  end

  // Arm solvers
  logic [STEP_W-1:0] s1, s2, s3;
  logic              f1, f2, f3;

  drik_arm #(.ITER(ITER)) u_arm1 (
    .clk(clk), .en(adv), .e(t6_e1), .f(t6_fz), .g(t6_g1),
    .spr(steps_per_rev), .steps(s1), .fault(f1)
  );
  drik_arm #(.ITER(ITER)) u_arm2 (
    .clk(clk), .en(adv), .e(t6_e2), .f(t6_fz), .g(t6_g2),
    .spr(steps_per_rev), .steps(s2), .fault(f2)
  );
  drik_arm #(.ITER(ITER)) u_arm3 (
    .clk(clk), .en(adv), .e(t6_e3), .f(t6_fz), .g(t6_g3),
    .spr(steps_per_rev), .steps(s3), .fault(f3)
  );

  assign arm1_steps  = $signed(s1);
  assign arm2_steps  = $signed(s2);
  assign arm3_steps  = $signed(s3);
  assign reach_fault = {f3, f2, f1};

endmodule
